/* design/nbps_pkg.sv */
// nbps_pkg: payload structs, register indexes and arithmetic widths for the
// pairwise frame step block. No dependencies.
`timescale 1ns / 1ps

package nbps_pkg;

    localparam int IDX_FIELD_W = 6;
    localparam int NUM_W       = 48;   // |d| << 16, |d| < 2^32
    localparam int DEN_W       = 64;   // force denominator
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE     = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic                   operation;
        logic [IDX_FIELD_W-1:0] load_index;
        logic signed [31:0]     load_x;
        logic signed [31:0]     load_y;
    } in_item_t;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0] particle_index;
        logic signed [31:0]     pos_x_out;
        logic signed [31:0]     pos_y_out;
        logic                   last_of_frame;
    } out_item_t;

endpackage

/* design/nbps_div.sv */
// nbps_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on nbps_pkg for operand widths.
`timescale 1ns / 1ps

module nbps_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [nbps_pkg::NUM_W-1:0] num,
    input  logic [nbps_pkg::DEN_W-1:0] den,
    output logic                       done,
    output logic [nbps_pkg::NUM_W-1:0] quot
);
    import nbps_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    always_comb begin
        rem_sh  = {rem_reg, num_reg[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            q_reg   <= {q_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* design/nbody_pairwise_frame_step_top.sv */
// nbody_pairwise_frame_step_top: 2D direct-sum particle frame stepper.
// Depends on nbps_pkg and nbps_div.
//
// Usage
//   s_* channel (valid/ready) carries in_item_t. operation = load writes one
//   particle's position and zeroes its velocity (no result). operation = step
//   runs one frame and returns min(particle_count, MAX_PARTICLES) result
//   transfers on m_*, in index order, last_of_frame on the final one.
//   cfg_* is a plain write port; write only while the block is idle.
// Timing
//   s_ready is high only while the sequencer is idle. A frame visits every
//   pair i<j through one shared 33x33 multiplier and one radix-2 divider.
//   The two divisions dominate the cost of a pair; a coincident pair skips
//   them and the velocity update. The integrate pass steps each particle
//   through S_IRD, S_ICALC and S_IOUT.
// Reset
//   aresetn (sync, active low) clears the sequencer, the output register,
//   the velocity valid bits (all velocities read zero) and restores the
//   register defaults. Positions are undefined until loaded.
// Stall
//   One output register; when m_ready is low the integrate pass waits
//   on the pending result and resumes on the next transfer.
`timescale 1ns / 1ps

module nbody_pairwise_frame_step_top #(
    parameter int MAX_PARTICLES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  nbps_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output nbps_pkg::out_item_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [nbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nbps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import nbps_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RD_I  = 5'd1;
    localparam logic [4:0] S_RD_J  = 5'd2;
    localparam logic [4:0] S_DIFF  = 5'd3;
    localparam logic [4:0] S_SQX   = 5'd4;
    localparam logic [4:0] S_SQY   = 5'd5;
    localparam logic [4:0] S_SADD  = 5'd6;
    localparam logic [4:0] S_F1    = 5'd7;
    localparam logic [4:0] S_F2    = 5'd8;
    localparam logic [4:0] S_F3    = 5'd9;
    localparam logic [4:0] S_DIVX  = 5'd10;
    localparam logic [4:0] S_WAITX = 5'd11;
    localparam logic [4:0] S_DIVY  = 5'd12;
    localparam logic [4:0] S_WAITY = 5'd13;
    localparam logic [4:0] S_VRD_I = 5'd14;
    localparam logic [4:0] S_VRD_J = 5'd15;
    localparam logic [4:0] S_VWR_J = 5'd16;
    localparam logic [4:0] S_NEXT  = 5'd17;
    localparam logic [4:0] S_IRD   = 5'd18;
    localparam logic [4:0] S_ICALC = 5'd19;
    localparam logic [4:0] S_IOUT  = 5'd20;

    // saturate a 33-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v[32] != v[31])
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return v[31:0];
    endfunction

    // signed, saturated pair term from an unsigned quotient
    function automatic logic signed [31:0] term(input logic [NUM_W-1:0] q,
                                                input logic neg);
        logic big;
        big = (q[NUM_W-1:31] != '0);
        if (neg)
            return big ? 32'sh8000_0000 : -$signed({1'b0, q[30:0]});
        return big ? 32'sh7FFF_FFFF : $signed({1'b0, q[30:0]});
    endfunction

    // -(v/2), division truncating toward zero
    function automatic logic signed [31:0] reflect(input logic signed [31:0] v);
        logic signed [31:0] half;
        half = (v + $signed({31'b0, v[31]})) >>> 1;
        return -half;
    endfunction

    // configuration
    logic [6:0]  pc_reg;
    logic [14:0] aw_reg;
    logic [14:0] ah_reg;
    logic [30:0] ts_reg;

    // sequencer
    logic [4:0]       state_reg;
    logic [CNT_W-1:0] i_reg, j_reg, n_reg;

    // datapath
    logic signed [31:0] pix_reg, piy_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [65:0]        prod_reg;
    logic [48:0]        s_reg;
    logic [63:0]        hi_reg;
    logic [63:0]        f_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic signed [31:0] opx_reg, opy_reg;
    logic signed [31:0] vxn_reg, vyn_reg;

    // memories
    logic signed [31:0] posx_mem [MAX_PARTICLES];
    logic signed [31:0] posy_mem [MAX_PARTICLES];
    logic signed [31:0] velx_mem [MAX_PARTICLES];
    logic signed [31:0] vely_mem [MAX_PARTICLES];
    logic [MAX_PARTICLES-1:0] vvalid_reg;
    logic signed [31:0] posx_rd_reg, posy_rd_reg, velx_rd_reg, vely_rd_reg;
    logic               vvalid_rd_reg;

    // output register
    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic             s_fire;
    logic             do_load;
    logic [CNT_W-1:0] n_calc;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      ax, ay;
    logic [32:0]      mul_a, mul_b;
    logic [64:0]      f_sum;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num, div_quot;
    logic signed [31:0] vx_rd, vy_rd;
    logic               v_we;
    logic [IDX_W-1:0]   v_waddr;
    logic signed [31:0] vx_wdata, vy_wdata;
    logic               out_free;
    logic               last_item;
    logic signed [32:0] nx, ny;
    logic signed [32:0] xb, yb;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign do_load  = s_fire && (s_data.operation == OP_LOAD) &&
                      ({1'b0, s_data.load_index} < 7'(MAX_PARTICLES));
    assign n_calc   = (pc_reg > 7'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES)
                                                   : CNT_W'(pc_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign last_item = ((CNT_W+1)'(i_reg) + 1'b1) == {1'b0, n_reg};

    assign rd_addr = (state_reg == S_RD_J || state_reg == S_VRD_J)
                   ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];

    assign vx_rd = vvalid_rd_reg ? velx_rd_reg : 32'sd0;
    assign vy_rd = vvalid_rd_reg ? vely_rd_reg : 32'sd0;

    always_comb begin
        logic [32:0] mx, my;
        mx = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        my = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        ax = mx[31:0];
        ay = my[31:0];
    end

    // shared multiplier operand select
    always_comb begin
        case (state_reg)
            S_SQX: begin
                mul_a = {1'b0, ax};
                mul_b = {1'b0, ax};
            end
            S_SQY: begin
                mul_a = {1'b0, ay};
                mul_b = {1'b0, ay};
            end
            S_F1: begin
                mul_a = s_reg[48:16];
                mul_b = {2'b0, ts_reg};
            end
            default: begin
                mul_a = {17'b0, s_reg[15:0]};
                mul_b = {2'b0, ts_reg};
            end
        endcase
    end

    assign f_sum = {1'b0, hi_reg} + {34'b0, prod_reg[46:16]};

    assign div_start = (state_reg == S_DIVX) || (state_reg == S_DIVY);
    assign div_num   = (state_reg == S_DIVX) ? {ax, 16'b0} : {ay, 16'b0};

    nbps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (f_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // velocity write port
    always_comb begin
        v_we     = 1'b0;
        v_waddr  = i_reg[IDX_W-1:0];
        vx_wdata = sat32(33'(vx_rd) + 33'(rx_reg));
        vy_wdata = sat32(33'(vy_rd) + 33'(ry_reg));
        case (state_reg)
            S_VRD_J: v_we = 1'b1;
            S_VWR_J: begin
                v_we     = 1'b1;
                v_waddr  = j_reg[IDX_W-1:0];
                vx_wdata = sat32(33'(vx_rd) - 33'(rx_reg));
                vy_wdata = sat32(33'(vy_rd) - 33'(ry_reg));
            end
            S_IOUT: begin
                v_we     = out_free;
                vx_wdata = vxn_reg;
                vy_wdata = vyn_reg;
            end
            default: v_we = 1'b0;
        endcase
    end

    assign nx = 33'(posx_rd_reg) + 33'(vx_rd);
    assign ny = 33'(posy_rd_reg) + 33'(vy_rd);
    assign xb = $signed({2'b0, aw_reg, 16'b0});
    assign yb = $signed({2'b0, ah_reg, 16'b0});

    // memories
    always_ff @(posedge aclk) begin
        posx_rd_reg <= posx_mem[rd_addr];
        posy_rd_reg <= posy_mem[rd_addr];
        velx_rd_reg <= velx_mem[rd_addr];
        vely_rd_reg <= vely_mem[rd_addr];
        if (do_load) begin
            posx_mem[s_data.load_index[IDX_W-1:0]] <= s_data.load_x;
            posy_mem[s_data.load_index[IDX_W-1:0]] <= s_data.load_y;
        end else if (state_reg == S_IOUT && out_free) begin
            posx_mem[i_reg[IDX_W-1:0]] <= sat32(33'(opx_reg) + 33'(vxn_reg));
            posy_mem[i_reg[IDX_W-1:0]] <= sat32(33'(opy_reg) + 33'(vyn_reg));
        end
        if (v_we) begin
            velx_mem[v_waddr] <= vx_wdata;
            vely_mem[v_waddr] <= vy_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vvalid_reg    <= '0;
            vvalid_rd_reg <= 1'b0;
        end else begin
            vvalid_rd_reg <= vvalid_reg[rd_addr];
            if (do_load)
                vvalid_reg[s_data.load_index[IDX_W-1:0]] <= 1'b0;
            else if (v_we)
                vvalid_reg[v_waddr] <= 1'b1;
        end
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= 7'd64;
            aw_reg <= 15'd640;
            ah_reg <= 15'd480;
            ts_reg <= 31'd65536;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PARTICLE_COUNT: pc_reg <= cfg_wdata[6:0];
                CFG_AREA_WIDTH:     aw_reg <= cfg_wdata[14:0];
                CFG_AREA_HEIGHT:    ah_reg <= cfg_wdata[14:0];
                CFG_TIME_SCALE:     ts_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !(state_reg == S_IOUT && out_free))
                m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_fire && s_data.operation == OP_STEP) begin
                        n_reg <= n_calc;
                        i_reg <= '0;
                        j_reg <= CNT_W'(1);
                        if (n_calc == CNT_W'(1))
                            state_reg <= S_IRD;
                        else if (n_calc != '0)
                            state_reg <= S_RD_I;
                    end
                end
                S_RD_I:  state_reg <= S_RD_J;
                S_RD_J:  state_reg <= S_DIFF;
                S_DIFF:  state_reg <= S_SQX;
                S_SQX:   state_reg <= (dx_reg == '0 && dy_reg == '0) ? S_NEXT : S_SQY;
                S_SQY:   state_reg <= S_SADD;
                S_SADD:  state_reg <= S_F1;
                S_F1:    state_reg <= S_F2;
                S_F2:    state_reg <= S_F3;
                S_F3:    state_reg <= S_DIVX;
                S_DIVX:  state_reg <= S_WAITX;
                S_WAITX: if (div_done) state_reg <= S_DIVY;
                S_DIVY:  state_reg <= S_WAITY;
                S_WAITY: if (div_done) state_reg <= S_VRD_I;
                S_VRD_I: state_reg <= S_VRD_J;
                S_VRD_J: state_reg <= S_VWR_J;
                S_VWR_J: state_reg <= S_NEXT;
                S_NEXT: begin
                    if (((CNT_W+1)'(j_reg) + 1'b1) < {1'b0, n_reg}) begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_RD_I;
                    end else if (((CNT_W+1)'(i_reg) + 2'd2) < {1'b0, n_reg}) begin
                        i_reg     <= i_reg + 1'b1;
                        j_reg     <= i_reg + 2'd2;
                        state_reg <= S_RD_I;
                    end else begin
                        i_reg     <= '0;
                        state_reg <= S_IRD;
                    end
                end
                S_IRD:   state_reg <= S_ICALC;
                S_ICALC: state_reg <= S_IOUT;
                S_IOUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (last_item) begin
                            state_reg <= S_IDLE;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_IRD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_RD_J: begin
                pix_reg <= posx_rd_reg;
                piy_reg <= posy_rd_reg;
            end
            S_DIFF: begin
                dx_reg <= 33'(posx_rd_reg) - 33'(pix_reg);
                dy_reg <= 33'(posy_rd_reg) - 33'(piy_reg);
            end
            S_SQY:  s_reg  <= {1'b0, prod_reg[63:16]};
            S_SADD: s_reg  <= s_reg + {1'b0, prod_reg[63:16]};
            S_F2:   hi_reg <= prod_reg[63:0];
            S_F3: begin
                if (f_sum[64])
                    f_reg <= '1;
                else if (f_sum[63:0] == '0)
                    f_reg <= 64'd1;
                else
                    f_reg <= f_sum[63:0];
            end
            S_WAITX: if (div_done) rx_reg <= term(div_quot, dx_reg[32]);
            S_WAITY: if (div_done) ry_reg <= term(div_quot, dy_reg[32]);
            S_ICALC: begin
                opx_reg <= posx_rd_reg;
                opy_reg <= posy_rd_reg;
                vxn_reg <= (nx >= xb || nx <= 0) ? reflect(vx_rd) : vx_rd;
                vyn_reg <= (ny >= yb || ny <= 0) ? reflect(vy_rd) : vy_rd;
            end
            S_IOUT: begin
                if (out_free) begin
                    m_data_reg.particle_index <= IDX_FIELD_W'(i_reg);
                    m_data_reg.pos_x_out      <= opx_reg;
                    m_data_reg.pos_y_out      <= opy_reg;
                    m_data_reg.last_of_frame  <= last_item;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // assertions
    a_div_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_WAITX || state_reg == S_WAITY))
        else $error("divider finished outside a wait state");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_VRD_J || state_reg == S_VWR_J) |-> (j_reg > i_reg))
        else $error("pair update with j not above i");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IOUT && out_free && last_item) |=>
        (m_valid && m_data.last_of_frame && s_ready))
        else $error("frame end not marked on the final result");

endmodule
